// File: rtl/ihrp_pkg.sv
// ihrp_pkg: shared types, result codes and character constants for the hex record parser
// no dependencies; imported by ihrp_front, ihrp_back, the core and the bench
package ihrp_pkg;

    // fixed field widths
    localparam int CNT_W  = 8;
    localparam int ADDR_W = 32;

    // result kinds
    localparam logic [2:0] K_DATA  = 3'd0;
    localparam logic [2:0] K_EMPTY = 3'd1;
    localparam logic [2:0] K_EOF   = 3'd2;
    localparam logic [2:0] K_EXT   = 3'd3;
    localparam logic [2:0] K_T05   = 3'd4;
    localparam logic [2:0] K_ERR   = 3'd5;

    // error codes
    localparam logic [2:0] E_OK    = 3'd0;
    localparam logic [2:0] E_HEX   = 3'd1;
    localparam logic [2:0] E_LEN   = 3'd2;
    localparam logic [2:0] E_SUM   = 3'd3;
    localparam logic [2:0] E_UNSUP = 3'd4;
    localparam logic [2:0] E_EXT   = 3'd5;
    localparam logic [2:0] E_EOF   = 3'd6;
    localparam logic [2:0] E_START = 3'd7;

    // record types
    localparam logic [7:0] REC_DATA  = 8'h00;
    localparam logic [7:0] REC_EOF   = 8'h01;
    localparam logic [7:0] REC_EXT   = 8'h04;
    localparam logic [7:0] REC_START = 8'h05;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_A_LC  = 8'h61;

    // line command from front to back
    typedef struct packed {
        logic             ovf;
        logic             bank;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    // buffer release from back to front
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    // one result item
    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_byte;
        logic [2:0]        error_code;
        logic              last;
    } t_result;

    // hex digit decode: bit 4 is valid, bits 3:0 the value
    function automatic logic [4:0] nibble_decode(input logic [7:0] c);
        logic [7:0] d;
        logic [7:0] l;
        d = c - CH_0;
        l = (c | 8'h20) - CH_A_LC;
        if (d <= 8'd9) begin
            return {1'b1, d[3:0]};
        end else if (l <= 8'd5) begin
            return {1'b1, l[3:0] + 4'd10};
        end else begin
            return 5'd0;
        end
    endfunction

endpackage

// File: rtl/ihrp_ram.sv
// ihrp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ihrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ihrp_fifo.sv
// ihrp_fifo: small register fifo used for the line command queue and the result queue
// no dependencies
module ihrp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/ihrp_front.sv
// ihrp_front: accepts characters, fills one of two line buffers, queues line commands
// depends on ihrp_pkg
module ihrp_front #(
    parameter int LINE_MAX = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [7:0]                    i_char,
    output logic                          o_full,
    output logic                          o_we,
    output logic [$clog2(LINE_MAX):0]     o_waddr,
    output logic [7:0]                    o_wdata,
    output logic                          o_cmd_push,
    output ihrp_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_full,
    input  ihrp_pkg::t_release            i_release
);
    import ihrp_pkg::*;

    localparam int IW = $clog2(LINE_MAX);

    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_busy, n_busy;
    logic             accept;

    // stall while the buffer to fill is still being decoded or the command queue is full
    assign o_full  = r_busy[r_bank] || i_cmd_full;
    assign accept  = i_push && !o_full;
    assign o_waddr = {r_bank, r_count[IW-1:0]};
    assign o_wdata = i_char;

    // classify the item
    always_comb begin
        n_bank     = r_bank;
        n_count    = r_count;
        n_busy     = r_busy;
        o_we       = 1'b0;
        o_cmd_push = 1'b0;
        o_cmd      = '{ovf: 1'b0, bank: r_bank, cnt: r_count};
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept) begin
            if (i_char == CH_CR) begin
                n_count = r_count;
            end else if (i_char == CH_LF) begin
                if (r_count != '0) begin
                    o_cmd_push     = 1'b1;
                    n_busy[r_bank] = 1'b1;
                    n_bank         = !r_bank;
                    n_count        = '0;
                end
            end else if (r_count >= CNT_W'(LINE_MAX)) begin
                o_cmd_push = 1'b1;
                o_cmd.ovf  = 1'b1;
            end else begin
                o_we    = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_count <= '0;
            r_busy  <= '0;
        end else begin
            r_bank  <= n_bank;
            r_count <= n_count;
            r_busy  <= n_busy;
        end
    end

`ifndef SYNTH
    // never overwrite a buffer under decode
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> !r_busy[r_bank])
        else $error("write into busy line buffer");

    // commands only go into a queue with room
    a_cmd_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_cmd_full)
        else $error("command pushed into full queue");

    // back only releases a buffer it holds
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_release.valid |-> r_busy[i_release.bank])
        else $error("release of idle line buffer");
`endif

endmodule

// File: rtl/ihrp_back.sv
// ihrp_back: decodes buffered lines, checks them and emits result items
// depends on ihrp_pkg; reads the line buffer ram through a registered port
module ihrp_back #(
    parameter int LINE_MAX = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_empty,
    input  ihrp_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_re,
    output logic [$clog2(LINE_MAX):0]     o_raddr,
    input  logic [7:0]                    i_rdata,
    output logic                          o_res_push,
    output ihrp_pkg::t_result             o_res,
    input  logic                          i_res_full,
    output ihrp_pkg::t_release            o_release
);
    import ihrp_pkg::*;

    localparam int IW = $clog2(LINE_MAX);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN     = 7'b0000010,
        S_CHECK    = 7'b0000100,
        S_SINGLE   = 7'b0001000,
        S_EMIT_HI  = 7'b0010000,
        S_EMIT_LO  = 7'b0100000,
        S_EMIT_PUT = 7'b1000000
    } t_bstate;

    t_bstate          r_state, n_state;
    logic             r_halt, n_halt;
    logic [15:0]      r_upper, n_upper;
    logic             r_pv, n_pv;
    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0] r_len, n_len;
    logic [31:0]      r_addr, n_addr;
    t_result          r_res, n_res;

    // scan results (payload)
    logic [CNT_W-1:0] r_pidx;
    logic [3:0]       r_hi;
    logic             r_hex_bad;
    logic             r_start_bad;
    logic [7:0]       r_sum;
    logic [7:0]       r_hdr [6];

    logic             start_line;
    logic [4:0]       nib;
    logic [7:0]       scan_byte;
    logic [CNT_W-1:0] hdr_j;
    logic [CNT_W-1:0] cnt_b;
    logic             len_bad;
    logic             field_bad;
    logic [2:0]       chk_err;
    logic [31:0]      base;
    t_result          data_res;

    assign nib       = nibble_decode(i_rdata);
    assign scan_byte = {r_hi, nib[3:0]};
    assign hdr_j     = (r_pidx >> 1) - CNT_W'(1);
    assign o_raddr   = {r_bank, r_rd_idx[IW-1:0]};

    // line checks in priority order
    assign cnt_b     = (r_n - CNT_W'(1)) >> 1;
    assign len_bad   = !r_n[0] || (r_n < CNT_W'(11));
    assign field_bad = (r_hdr[0] != cnt_b - CNT_W'(5));
    assign base      = {r_upper, r_hdr[1], r_hdr[2]};

    always_comb begin
        if (r_start_bad) begin
            chk_err = E_START;
        end else if (len_bad) begin
            chk_err = E_LEN;
        end else if (r_hex_bad) begin
            chk_err = E_HEX;
        end else if (field_bad) begin
            chk_err = E_LEN;
        end else if (r_sum != 8'd0) begin
            chk_err = E_SUM;
        end else begin
            chk_err = E_OK;
        end
    end

    // data byte item assembled from the held read data
    always_comb begin
        data_res            = '0;
        data_res.kind       = K_DATA;
        data_res.address    = r_addr;
        data_res.data_byte  = scan_byte;
        data_res.error_code = E_OK;
        data_res.last       = (r_len == CNT_W'(1));
    end

    assign o_res = (r_state == S_EMIT_PUT) ? data_res : r_res;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_halt     = r_halt;
        n_upper    = r_upper;
        n_bank     = r_bank;
        n_n        = r_n;
        n_rd_idx   = r_rd_idx;
        n_len      = r_len;
        n_addr     = r_addr;
        n_res      = r_res;
        n_pv       = 1'b0;
        o_cmd_pop  = 1'b0;
        o_re       = 1'b0;
        o_res_push = 1'b0;
        o_release  = '0;
        start_line = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (r_halt) begin
                        o_release.valid = !i_cmd.ovf;
                        o_release.bank  = i_cmd.bank;
                    end else if (i_cmd.ovf) begin
                        n_halt           = 1'b1;
                        n_res            = '0;
                        n_res.kind       = K_ERR;
                        n_res.error_code = E_LEN;
                        n_res.last       = 1'b1;
                        n_state          = S_SINGLE;
                    end else begin
                        start_line = 1'b1;
                        n_bank     = i_cmd.bank;
                        n_n        = i_cmd.cnt;
                        n_rd_idx   = '0;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_idx < r_n) begin
                    o_re     = 1'b1;
                    n_pv     = 1'b1;
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end else if (!r_pv) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_release.valid = 1'b1;
                o_release.bank  = r_bank;
                n_res           = '0;
                n_res.last      = 1'b1;
                n_state         = S_SINGLE;
                if (chk_err != E_OK) begin
                    n_halt           = 1'b1;
                    n_res.kind       = K_ERR;
                    n_res.error_code = chk_err;
                end else begin
                    case (r_hdr[3])
                        REC_DATA: begin
                            if (r_hdr[0] == 8'd0) begin
                                n_res.kind    = K_EMPTY;
                                n_res.address = base;
                            end else begin
                                o_release.valid = 1'b0;
                                n_len           = r_hdr[0];
                                n_addr          = base;
                                n_rd_idx        = CNT_W'(9);
                                n_state         = S_EMIT_HI;
                            end
                        end
                        REC_EOF: begin
                            n_halt = 1'b1;
                            if (r_hdr[0] != 8'd0 || r_hdr[1] != 8'd0 || r_hdr[2] != 8'd0) begin
                                n_res.kind       = K_ERR;
                                n_res.error_code = E_EOF;
                            end else begin
                                n_res.kind = K_EOF;
                            end
                        end
                        REC_EXT: begin
                            if (r_hdr[0] != 8'd2 || r_hdr[1] != 8'd0 || r_hdr[2] != 8'd0) begin
                                n_halt           = 1'b1;
                                n_res.kind       = K_ERR;
                                n_res.error_code = E_EXT;
                            end else begin
                                n_upper       = {r_hdr[4], r_hdr[5]};
                                n_res.kind    = K_EXT;
                                n_res.address = {r_hdr[4], r_hdr[5], 16'h0000};
                            end
                        end
                        REC_START: begin
                            n_res.kind = K_T05;
                        end
                        default: begin
                            n_halt           = 1'b1;
                            n_res.kind       = K_ERR;
                            n_res.error_code = E_UNSUP;
                        end
                    endcase
                end
            end
            S_SINGLE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EMIT_HI: begin
                o_re     = 1'b1;
                n_rd_idx = r_rd_idx + CNT_W'(1);
                n_state  = S_EMIT_LO;
            end
            S_EMIT_LO: begin
                o_re     = 1'b1;
                n_rd_idx = r_rd_idx + CNT_W'(1);
                n_state  = S_EMIT_PUT;
            end
            S_EMIT_PUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_addr     = r_addr + 32'd1;
                    n_len      = r_len - CNT_W'(1);
                    if (r_len == CNT_W'(1)) begin
                        o_release.valid = 1'b1;
                        o_release.bank  = r_bank;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_EMIT_HI;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_halt  <= 1'b0;
            r_upper <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_halt  <= n_halt;
            r_upper <= n_upper;
            r_pv    <= n_pv;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bank   <= n_bank;
        r_n      <= n_n;
        r_rd_idx <= n_rd_idx;
        r_len    <= n_len;
        r_addr   <= n_addr;
        r_res    <= n_res;
        r_pidx   <= r_rd_idx;
    end

    // scan of returned characters: start, hex digits, sum, header bytes
    always_ff @(posedge i_clk) begin
        if (start_line) begin
            r_hex_bad   <= 1'b0;
            r_start_bad <= 1'b0;
            r_sum       <= 8'd0;
        end else if (r_pv) begin
            if (r_pidx == '0) begin
                r_start_bad <= (i_rdata != CH_COLON);
            end else if (r_pidx[0]) begin
                r_hi      <= nib[3:0];
                r_hex_bad <= r_hex_bad || !nib[4];
            end else begin
                r_hex_bad <= r_hex_bad || !nib[4];
                r_sum     <= r_sum + scan_byte;
                if (r_pidx <= CNT_W'(12)) begin
                    r_hdr[hdr_j[2:0]] <= scan_byte;
                end
            end
        end
        if (r_state == S_EMIT_LO) begin
            r_hi <= nib[3:0];
        end
    end

`ifndef SYNTH
    // results only go into a queue with room
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    // errors and eof stay in force
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt cleared");

    // an error item leaves the block halted
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.kind == K_ERR) |-> r_halt)
        else $error("error item without halt");

    // data items come from the emit step only
    a_data_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.kind == K_DATA) |-> (r_state == S_EMIT_PUT))
        else $error("data item outside emit");
`endif

endmodule

// File: rtl/intel_hex_record_parser_core.sv
// intel_hex_record_parser_core: a character is accepted per cycle while full is low; full stays
// high while the next line buffer is still being decoded. A line is decoded by a scan of its
// characters and a check, then each data byte by its own emit steps (high digit, low digit, put)
// through the single registered ram read port; a queued result shows in the cycle after its push.
// Synchronous active-low reset clears all control state; the line buffers need no clearing.
// depends on ihrp_pkg, ihrp_front, ihrp_back, ihrp_fifo, ihrp_ram
module intel_hex_record_parser_core #(
    parameter int LINE_MAX = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_in,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [31:0] o_address,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_error_code,
    output logic        o_last
);
    import ihrp_pkg::*;

    localparam int AW = $clog2(LINE_MAX) + 1;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [7:0]             wdata;
    logic                   re;
    logic [AW-1:0]          raddr;
    logic [7:0]             rdata;
    logic                   cmd_push;
    t_cmd                   cmd_in;
    logic                   cmd_full;
    logic                   cmd_pop;
    logic [$bits(t_cmd)-1:0] cmd_vec;
    t_cmd                   cmd_out;
    logic                   cmd_empty;
    t_release               release_s;
    logic                   res_push;
    t_result                res_in;
    logic                   res_full;
    logic [$bits(t_result)-1:0] res_vec;
    t_result                res_out;

    // front: accept and buffer characters
    ihrp_front #(.LINE_MAX(LINE_MAX)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_char     (i_char_in),
        .o_full     (full),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full),
        .i_release  (release_s)
    );

    // two line buffers in one ram
    ihrp_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // line command queue
    ihrp_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(2)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_vec),
        .o_empty (cmd_empty)
    );

    assign cmd_out = t_cmd'(cmd_vec);

    // back: decode lines and emit items
    ihrp_back #(.LINE_MAX(LINE_MAX)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full),
        .o_release   (release_s)
    );

    // result queue
    ihrp_fifo #(.WIDTH($bits(t_result)), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_vec),
        .o_empty (empty)
    );

    assign res_out      = t_result'(res_vec);
    assign o_kind       = res_out.kind;
    assign o_address    = res_out.address;
    assign o_data_byte  = res_out.data_byte;
    assign o_error_code = res_out.error_code;
    assign o_last       = res_out.last;

endmodule

// File: bench/intel_hex_record_parser_checker.sv
// intel_hex_record_parser_checker: predicts the result items of the hex record parser from the
// accepted characters and compares them, field by field, with the items popped at the output
// depends on ihrp_pkg; instantiated beside the parser by intel_hex_record_parser_core_tb
module intel_hex_record_parser_checker #(
    parameter int LINE_MAX = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_char_in,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_address,
    input  logic [7:0]  i_data_byte,
    input  logic [2:0]  i_error_code,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ihrp_pkg::*;

    // predicted parser state
    logic [7:0]  line_buf [LINE_MAX];
    int unsigned line_len;
    logic [15:0] upper_addr;
    bit          eof_seen;
    logic [2:0]  halt_code;

    // result items predicted but not yet popped, oldest first
    t_result     pending_results [$];
    int          fail_count    = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // value of a hex digit, -1 for any other character
    function automatic int hex_value(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= CH_0 && c <= CH_0 + 8'd9) begin
            return int'(c - CH_0);
        end
        if (folded >= CH_A_LC && folded <= CH_A_LC + 8'd5) begin
            return int'(folded - CH_A_LC) + 10;
        end
        return -1;
    endfunction

    function automatic void queue_result(input logic [2:0] kind, input logic [31:0] addr,
                                         input logic [7:0] data, input logic [2:0] code,
                                         input logic fin);
        t_result r;
        r.kind       = kind;
        r.address    = addr;
        r.data_byte  = data;
        r.error_code = code;
        r.last       = fin;
        pending_results.push_back(r);
    endfunction

    // any failed check halts the parser for good
    function automatic void raise_error(input logic [2:0] code);
        halt_code = code;
        queue_result(K_ERR, 32'h0, 8'h0, code, 1'b1);
    endfunction

    // advance the predicted state by one character, queueing what it causes
    task automatic parse_char(input logic [7:0] c);
        logic [7:0]  rec [LINE_MAX / 2 + 1];
        logic [7:0]  sum;
        logic [31:0] base;
        int unsigned n;
        int unsigned nbytes;
        int unsigned len;
        int          hv;
        int          lv;
        if (halt_code != E_OK || eof_seen) return;
        if (c == CH_CR) return;
        // buffer ordinary characters, overflow is a length error
        if (c != CH_LF) begin
            if (line_len >= LINE_MAX) begin
                raise_error(E_LEN);
            end else begin
                line_buf[line_len] = c;
                line_len++;
            end
            return;
        end
        if (line_len == 0) return;
        n        = line_len;
        line_len = 0;
        // framing checks
        if (line_buf[0] != CH_COLON) begin
            raise_error(E_START);
            return;
        end
        if (n % 2 == 0 || n < 11) begin
            raise_error(E_LEN);
            return;
        end
        // digit pairs to bytes
        nbytes = (n - 1) / 2;
        for (int i = 0; i < nbytes; i++) begin
            hv = hex_value(line_buf[1 + 2 * i]);
            lv = hex_value(line_buf[2 + 2 * i]);
            if (hv < 0 || lv < 0) begin
                raise_error(E_HEX);
                return;
            end
            rec[i] = 8'(hv * 16 + lv);
        end
        if (rec[0] != 8'(nbytes - 5)) begin
            raise_error(E_LEN);
            return;
        end
        sum = 8'h0;
        for (int i = 0; i < nbytes; i++) begin
            sum += rec[i];
        end
        if (sum != 8'h0) begin
            raise_error(E_SUM);
            return;
        end
        // record type handling
        case (rec[3])
            REC_DATA: begin
                len  = rec[0];
                base = {upper_addr, rec[1], rec[2]};
                if (len == 0) begin
                    queue_result(K_EMPTY, base, 8'h0, E_OK, 1'b1);
                end else begin
                    for (int i = 0; i < len; i++) begin
                        queue_result(K_DATA, base + 32'(i), rec[4 + i], E_OK, i == len - 1);
                    end
                end
            end
            REC_EOF: begin
                if (rec[0] != 8'h00 || rec[1] != 8'h00 || rec[2] != 8'h00) begin
                    raise_error(E_EOF);
                end else begin
                    eof_seen = 1'b1;
                    queue_result(K_EOF, 32'h0, 8'h0, E_OK, 1'b1);
                end
            end
            REC_EXT: begin
                if (rec[0] != 8'h02 || rec[1] != 8'h00 || rec[2] != 8'h00) begin
                    raise_error(E_EXT);
                end else begin
                    upper_addr = {rec[4], rec[5]};
                    queue_result(K_EXT, {upper_addr, 16'h0}, 8'h0, E_OK, 1'b1);
                end
            end
            REC_START: begin
                queue_result(K_T05, 32'h0, 8'h0, E_OK, 1'b1);
            end
            default: begin
                raise_error(E_UNSUP);
            end
        endcase
    endtask

    // compare popped items first, then predict from the accepted character
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            line_len   = 0;
            upper_addr = 16'h0;
            eof_seen   = 1'b0;
            halt_code  = E_OK;
            pending_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("item kind %0d address 0x%08h with none expected",
                                              i_kind, i_address));
                end else begin
                    want = pending_results.pop_front();
                    if (i_kind !== want.kind) begin
                        report_mismatch($sformatf("kind got %0d expected %0d",
                                                  i_kind, want.kind));
                    end
                    if (i_address !== want.address) begin
                        report_mismatch($sformatf("address got 0x%08h expected 0x%08h",
                                                  i_address, want.address));
                    end
                    if (i_data_byte !== want.data_byte) begin
                        report_mismatch($sformatf("data_byte got 0x%02h expected 0x%02h",
                                                  i_data_byte, want.data_byte));
                    end
                    if (i_error_code !== want.error_code) begin
                        report_mismatch($sformatf("error_code got %0d expected %0d",
                                                  i_error_code, want.error_code));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last got %0b expected %0b",
                                                  i_last, want.last));
                    end
                end
            end
            if (i_push && !i_full) begin
                parse_char(i_char_in);
            end
        end
        pending_count = pending_results.size();
    end

endmodule

// File: bench/intel_hex_record_parser_core_tb.sv
// intel_hex_record_parser_core_tb: drives hex text into the parser and drains its result items,
// with random idling on both sides; the checker beside the parser predicts and compares
// depends on ihrp_pkg, intel_hex_record_parser_core, intel_hex_record_parser_checker
module intel_hex_record_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ihrp_pkg::*;

    localparam int         LINE_MAX     = 128;
    localparam int         RANDOM_CHARS = 100;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         TAIL_CYCLES  = 200;
    localparam logic [7:0] CH_A_UC      = 8'h41;

    // how the stream is brought to its halt
    typedef enum int {
        END_EOF_OK,
        END_EOF_BAD,
        END_EXT_BAD,
        END_UNSUP,
        END_SUM,
        END_LEN_FIELD,
        END_HEX,
        END_START,
        END_SHORT,
        END_EVEN,
        END_OVERFLOW
    } t_end_case;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    logic        pop     = 1'b0;
    logic [7:0]  char_in = 8'h0;
    logic        full;
    logic        empty;
    logic [2:0]  kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic        last;
    int          fail_count;
    int          pending;

    bit          hold_request = 1'b0;
    bit          quiet_tail   = 1'b0;
    bit          sender_idle  = 1'b0;
    int          record_chars = 0;
    logic [7:0]  text_q [$];
    logic [7:0]  payload [$];

    intel_hex_record_parser_core #(
        .LINE_MAX(LINE_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_char_in   (char_in),
        .empty       (empty),
        .pop         (pop),
        .o_kind      (kind),
        .o_address   (address),
        .o_data_byte (data_byte),
        .o_error_code(error_code),
        .o_last      (last)
    );

    intel_hex_record_parser_checker #(
        .LINE_MAX(LINE_MAX)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_char_in   (char_in),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_kind      (kind),
        .i_address   (address),
        .i_data_byte (data_byte),
        .i_error_code(error_code),
        .i_last      (last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial begin
        forever #1 clk = ~clk;
    end

    // hex digit with random letter case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_0 + 8'(v);
        return ($urandom_range(0, 1) ? CH_A_UC : CH_A_LC) + 8'(v - 4'd10);
    endfunction

    function automatic void add_hex(input logic [7:0] b);
        text_q.push_back(hex_char(b[7:4]));
        text_q.push_back(hex_char(b[3:0]));
    endfunction

    function automatic void fill_payload(input int n);
        payload.delete();
        repeat (n) payload.push_back(8'($urandom_range(0, 255)));
    endfunction

    // any character but the line ends, optionally not the colon either
    function automatic logic [7:0] stray_char(input bit no_colon);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_LF || c == CH_CR || (no_colon && c == CH_COLON)) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // record text from payload; nonzero adjustments break the length or checksum field
    function automatic void build_record(input logic [7:0] rtype, input logic [15:0] offs,
                                         input logic [7:0] len_adj, input logic [7:0] sum_adj);
        logic [7:0] len;
        logic [7:0] sum;
        len = 8'(payload.size()) + len_adj;
        sum = len + offs[15:8] + offs[7:0] + rtype;
        foreach (payload[i]) sum += payload[i];
        text_q.delete();
        text_q.push_back(CH_COLON);
        add_hex(len);
        add_hex(offs[15:8]);
        add_hex(offs[7:0]);
        add_hex(rtype);
        foreach (payload[i]) add_hex(payload[i]);
        add_hex(8'(8'h0 - sum) + sum_adj);
    endfunction

    // one item on the input side, with an occasional idle burst before it
    task automatic send_char(input logic [7:0] c);
        int gap;
        @(negedge clk);
        if (sender_idle && !quiet_tail && $urandom_range(0, 99) < 6) begin
            gap = $urandom_range(1, 18);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        char_in <= c;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // send the built line, sometimes with a stray CR inside it
    task automatic send_line(input bit with_eol);
        int cr_at;
        cr_at       = ($urandom_range(0, 19) == 0) ? $urandom_range(0, text_q.size() - 1) : -1;
        sender_idle = ($urandom_range(0, 3) != 0);
        foreach (text_q[i]) begin
            if (i == cr_at) send_char(CH_CR);
            send_char(text_q[i]);
        end
        record_chars += text_q.size();
        if (with_eol) begin
            if ($urandom_range(0, 1)) send_char(CH_CR);
            send_char(CH_LF);
        end
    endtask

    // result side: random stall bursts, calm stretches, and one long hold-off
    initial begin
        int  burst;
        int  hold;
        int  mode_left;
        bit  idle_mode;
        burst     = 0;
        hold      = 0;
        mode_left = 0;
        idle_mode = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold         = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                idle_mode = ($urandom_range(0, 2) != 0);
                mode_left = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            if (hold > 0) begin
                hold--;
            end else if (burst > 0) begin
                burst--;
            end else if (idle_mode && !quiet_tail && $urandom_range(0, 99) < 12) begin
                burst = $urandom_range(1, 18);
            end
            pop <= (hold == 0 && burst == 0);
        end
    end

    // watchdog on cycles with no item moving on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial begin
        int          line_no;
        int          sel;
        int          n;
        logic [15:0] offs;
        logic [7:0]  rtype;
        t_end_case   ending;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: blank lines, byte extremes, empty record at top address
        sender_idle = 1'b0;
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_LF);
        payload = {8'h00, 8'hFF};
        build_record(REC_DATA, 16'h0000, 8'h0, 8'h0);
        send_line(1'b1);
        payload.delete();
        build_record(REC_DATA, 16'hFFFF, 8'h0, 8'h0);
        send_line(1'b1);
        // top upper address, then a record that wraps past the top of the space
        payload = {8'hFF, 8'hFF};
        build_record(REC_EXT, 16'h0000, 8'h0, 8'h0);
        send_line(1'b1);
        fill_payload(4);
        build_record(REC_DATA, 16'hFFFE, 8'h0, 8'h0);
        send_line(1'b1);
        fill_payload(4);
        build_record(REC_START, 16'($urandom_range(0, 16'hFFFF)), 8'h0, 8'h0);
        send_line(1'b1);
        payload = {8'h00, 8'h00};
        build_record(REC_EXT, 16'h0000, 8'h0, 8'h0);
        send_line(1'b1);
        // longest data record that fits the line buffer
        fill_payload(58);
        build_record(REC_DATA, 16'h8000, 8'h0, 8'h0);
        send_line(1'b1);
        fill_payload(1);
        build_record(REC_DATA, 16'hFFFF, 8'h0, 8'h0);
        send_line(1'b1);

        // random well-formed records
        record_chars = 0;
        line_no      = 0;
        while (record_chars < RANDOM_CHARS || line_no < 3) begin
            line_no++;
            if (record_chars * 5 > RANDOM_CHARS * 4) quiet_tail = 1'b1;
            if (line_no == 1) begin
                // stop the result side and keep offering a long record to fill the block
                hold_request = 1'b1;
                fill_payload(30);
                build_record(REC_DATA, 16'($urandom_range(0, 16'hFFFF)), 8'h0, 8'h0);
                send_line(1'b1);
            end
            if (line_no == 3) begin
                // sender pause until the result side has drained
                @(negedge clk);
                push <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 58) : $urandom_range(1, 8);
                offs = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                                   : 16'($urandom_range(0, 16'hFFFF));
                fill_payload(n);
                build_record(REC_DATA, offs, 8'h0, 8'h0);
                send_line(1'b1);
            end else if (sel < 70) begin
                case ($urandom_range(0, 3))
                    0:       offs = 16'h0000;
                    1:       offs = 16'hFFFF;
                    default: offs = 16'($urandom_range(0, 16'hFFFF));
                endcase
                payload = {offs[15:8], offs[7:0]};
                build_record(REC_EXT, 16'h0000, 8'h0, 8'h0);
                send_line(1'b1);
            end else if (sel < 78) begin
                fill_payload($urandom_range(0, 8));
                build_record(REC_START, 16'($urandom_range(0, 16'hFFFF)), 8'h0, 8'h0);
                send_line(1'b1);
            end else if (sel < 85) begin
                payload.delete();
                build_record(REC_DATA, 16'($urandom_range(0, 16'hFFFF)), 8'h0, 8'h0);
                send_line(1'b1);
            end else begin
                if ($urandom_range(0, 1)) send_char(CH_CR);
                send_char(CH_LF);
            end
        end

        // final line: a valid eof or one broken record, which halts the parser
        quiet_tail = 1'b1;
        ending     = t_end_case'($urandom_range(0, int'(END_OVERFLOW)));
        fill_payload($urandom_range(1, 6));
        build_record(REC_DATA, 16'($urandom_range(0, 16'hFFFF)), 8'h0, 8'h0);
        case (ending)
            END_EOF_OK: begin
                payload.delete();
                build_record(REC_EOF, 16'h0000, 8'h0, 8'h0);
            end
            END_EOF_BAD: begin
                n = $urandom_range(0, 2);
                fill_payload(n);
                build_record(REC_EOF, 16'($urandom_range(n == 0 ? 1 : 0, 16'hFFFF)),
                             8'h0, 8'h0);
            end
            END_EXT_BAD: begin
                n = $urandom_range(0, 4);
                fill_payload(n);
                build_record(REC_EXT, 16'($urandom_range(n == 2 ? 1 : 0, 16'hFFFF)),
                             8'h0, 8'h0);
            end
            END_UNSUP: begin
                case ($urandom_range(0, 2))
                    0:       rtype = 8'h02;
                    1:       rtype = 8'h03;
                    default: rtype = 8'($urandom_range(6, 255));
                endcase
                fill_payload($urandom_range(0, 4));
                build_record(rtype, 16'($urandom_range(0, 16'hFFFF)), 8'h0, 8'h0);
            end
            END_SUM: begin
                build_record(REC_DATA, 16'h0000, 8'h0, 8'($urandom_range(1, 255)));
            end
            END_LEN_FIELD: begin
                build_record(REC_DATA, 16'h0000, 8'($urandom_range(1, 255)), 8'h0);
            end
            END_HEX: begin
                n = $urandom_range(1, text_q.size() - 1);
                case ($urandom_range(0, 3))
                    0:       text_q[n] = 8'($urandom_range(8'h80, 8'hFF));
                    1:       text_q[n] = 8'($urandom_range(8'h67, 8'h7A));
                    2:       text_q[n] = 8'($urandom_range(8'h47, 8'h5A));
                    default: text_q[n] = CH_COLON;
                endcase
            end
            END_START: begin
                text_q[0] = stray_char(1'b1);
            end
            END_SHORT: begin
                text_q.delete();
                text_q.push_back(CH_COLON);
                repeat ($urandom_range(0, 4)) add_hex(8'($urandom_range(0, 255)));
            end
            END_EVEN: begin
                text_q.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            default: begin
                text_q.delete();
                repeat ($urandom_range(LINE_MAX + 1, LINE_MAX + 12)) begin
                    text_q.push_back(stray_char(1'b0));
                end
            end
        endcase
        send_line(ending != END_OVERFLOW);

        // anything after the halt must be ignored
        repeat (40) send_char(8'($urandom_range(0, 255)));

        @(negedge clk);
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
